### hw/rtl/lsf_pkg.sv
// Package for the least-squares line fitter: shared types, codes and the
// saturation helper. Depends on nothing; every file but lsf_ifs imports it.
package lsf_pkg;

    // Input operation codes and result kinds.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_EVAL   = 1'b1;
    localparam logic KIND_FIT  = 1'b0;
    localparam logic KIND_PRED = 1'b1;

    // Saturated result widths.
    localparam int SLOPE_W = 40;
    localparam int ICPT_W  = 48;
    localparam int CORR_W  = 16;

    // Operations of the shared serial arithmetic unit.
    typedef enum logic [1:0] {
        AOP_MUL,
        AOP_DIV,
        AOP_SQRT
    } t_aop;

    typedef struct packed {
        logic start;
        t_aop op;
    } t_arith_req;

    // One job handed from the front end to the back end.
    typedef struct packed {
        logic               op;
        logic signed [15:0] x;
        logic               ovf;
        logic [63:0]        n;
        logic signed [63:0] sx;
        logic signed [63:0] sy;
        logic signed [63:0] sxx;
        logic signed [63:0] syy;
        logic signed [63:0] sxy;
    } t_job;

    // Steps of the back-end sequencer.
    typedef enum logic [3:0] {
        B_IDLE,
        B_NXX_A,
        B_NXX_B,
        B_NYY_A,
        B_NYY_B,
        B_NXY_A,
        B_NXY_B,
        B_SLOPE,
        B_SXPROD,
        B_ICPT,
        B_PROD_NN,
        B_ROOT,
        B_CORR,
        B_PRED,
        B_OUT
    } t_bstate;

    // Clamp a signed 128-bit value to a signed field of w bits.
    function automatic logic signed [63:0] sat_to(input logic signed [127:0] v,
                                                  input int w);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (w - 1)) - 128'sd1;
        lo = -hi - 128'sd1;
        if (v > hi) begin
            return hi[63:0];
        end else if (v < lo) begin
            return lo[63:0];
        end
        return v[63:0];
    endfunction

endpackage

### hw/rtl/lsf_ifs.sv
// Valid/ready channel interfaces of the line fitter: one for sample and
// query items, one for results. No dependencies.
interface lsf_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic               last_sample;

    modport source (output valid, op, x_value, y_value, last_sample, input ready);
    modport sink   (input valid, op, x_value, y_value, last_sample, output ready);
endinterface

interface lsf_out_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic signed [39:0] slope;
    logic signed [47:0] intercept;
    logic signed [15:0] correlation;
    logic signed [47:0] prediction;
    logic               degenerate;
    logic               overflowed;

    modport source (output valid, result_kind, slope, intercept, correlation,
                    prediction, degenerate, overflowed, input ready);
    modport sink   (input valid, result_kind, slope, intercept, correlation,
                    prediction, degenerate, overflowed, output ready);
endinterface

### hw/rtl/lsf_arith.sv
// Shared serial arithmetic unit: signed multiply, rounded signed divide and
// integer square root, one bit or one digit per cycle. Uses lsf_pkg.
module lsf_arith (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lsf_pkg::t_arith_req i_req,
    input  logic signed [127:0] i_a,
    input  logic [63:0]         i_b,
    output logic                o_done,
    output logic signed [127:0] o_res
);
    import lsf_pkg::*;

    localparam int CNT_W = 8;

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    t_aop               r_op, n_op;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_neg, n_neg;
    logic               r_zero, n_zero;
    logic [127:0]       r_a, n_a;
    logic [63:0]        r_b, n_b;
    logic [127:0]       r_acc, n_acc;
    logic [64:0]        r_rem, n_rem;

    logic signed [63:0] a64;
    logic signed [63:0] b64;
    logic [127:0]       num_mag;
    logic [64:0]        div_sh;
    logic [65:0]        sq_sh;
    logic [65:0]        sq_trial;

    always_comb begin
        a64      = i_a[63:0];
        b64      = i_b;
        num_mag  = i_a[127] ? 128'(-i_a) : 128'(i_a);
        div_sh   = {r_rem[63:0], r_a[127]};
        sq_sh    = {r_rem[63:0], r_a[127:126]};
        sq_trial = {r_acc[63:0], 2'b01};

        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_zero = r_zero;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_rem  = r_rem;

        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_acc  = '0;
            n_rem  = '0;
            n_zero = 1'b0;
            case (i_req.op)
                AOP_MUL: begin
                    n_a   = {64'd0, (a64 < 0) ? 64'(-a64) : 64'(a64)};
                    n_b   = (b64 < 0) ? 64'(-b64) : 64'(b64);
                    n_neg = (a64 < 0) ^ (b64 < 0);
                    n_cnt = CNT_W'(64);
                end
                AOP_DIV: begin
                    n_a    = num_mag + {64'd0, i_b >> 1};
                    n_b    = i_b;
                    n_neg  = i_a[127];
                    n_zero = (i_b == '0);
                    n_cnt  = CNT_W'(128);
                end
                default: begin
                    n_a   = i_a;
                    n_b   = '0;
                    n_neg = 1'b0;
                    n_cnt = CNT_W'(64);
                end
            endcase
        end else if (r_busy) begin
            case (r_op)
                AOP_MUL: begin
                    if (r_b[0]) begin
                        n_acc = r_acc + r_a;
                    end
                    n_a = r_a << 1;
                    n_b = r_b >> 1;
                end
                AOP_DIV: begin
                    if (div_sh >= {1'b0, r_b}) begin
                        n_rem = div_sh - {1'b0, r_b};
                        n_acc = {r_acc[126:0], 1'b1};
                    end else begin
                        n_rem = div_sh;
                        n_acc = {r_acc[126:0], 1'b0};
                    end
                    n_a = r_a << 1;
                end
                default: begin
                    if (sq_sh >= sq_trial) begin
                        n_rem = 65'(sq_sh - sq_trial);
                        n_acc = {r_acc[126:0], 1'b1};
                    end else begin
                        n_rem = 65'(sq_sh);
                        n_acc = {r_acc[126:0], 1'b0};
                    end
                    n_a = r_a << 2;
                end
            endcase
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op   <= n_op;
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_zero <= n_zero;
        r_a    <= n_a;
        r_b    <= n_b;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
    end

    assign o_done = r_done;
    assign o_res  = r_zero ? '0 : (r_neg ? -$signed(r_acc) : $signed(r_acc));

    a_no_start_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("arith unit started while busy");

endmodule

### hw/rtl/lsf_queue.sv
// Two-entry job queue between the front end and the back end of the line
// fitter. Uses lsf_pkg for the job type.
module lsf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lsf_pkg::t_job i_job,
    input  logic          i_pop,
    output lsf_pkg::t_job o_job,
    output logic          o_valid,
    output logic          o_full
);
    import lsf_pkg::*;

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [AW:0]     r_cnt, n_cnt;

    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop  ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rd];
    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (AW+1)'(DEPTH));

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("job pushed into a full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("job popped from an empty queue");

endmodule

### hw/rtl/lsf_front.sv
// Front end of the line fitter: takes sample and query transfers, keeps the
// running sums and hands closed sets and queries on as jobs. Uses lsf_pkg.
module lsf_front #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lsf_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output lsf_pkg::t_job o_job
);
    import lsf_pkg::*;

    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int SXW = 16 + CW;
    localparam int SQW = 31 + CW;

    logic [CW-1:0]         r_count, n_count, u_count;
    logic signed [SXW-1:0] r_sx, n_sx, u_sx;
    logic signed [SXW-1:0] r_sy, n_sy, u_sy;
    logic signed [SQW-1:0] r_sxx, n_sxx, u_sxx;
    logic signed [SQW-1:0] r_syy, n_syy, u_syy;
    logic signed [SQW-1:0] r_sxy, n_sxy, u_sxy;
    logic                  r_ovf, n_ovf, u_ovf;

    logic                  accept;
    logic                  sample;
    logic                  room;
    logic                  close_set;
    logic signed [31:0]    pxx, pyy, pxy;

    always_comb begin
        accept    = i_in.valid && i_in.ready;
        sample    = accept && (i_in.op == OP_LOAD);
        room      = (r_count != CW'(MAX_SAMPLES));
        close_set = sample && i_in.last_sample;
        pxx       = i_in.x_value * i_in.x_value;
        pyy       = i_in.y_value * i_in.y_value;
        pxy       = i_in.x_value * i_in.y_value;

        u_count = r_count;
        u_sx    = r_sx;
        u_sy    = r_sy;
        u_sxx   = r_sxx;
        u_syy   = r_syy;
        u_sxy   = r_sxy;
        u_ovf   = r_ovf;
        if (sample) begin
            if (room) begin
                u_count = r_count + 1'b1;
                u_sx    = r_sx + SXW'(i_in.x_value);
                u_sy    = r_sy + SXW'(i_in.y_value);
                u_sxx   = r_sxx + SQW'(pxx);
                u_syy   = r_syy + SQW'(pyy);
                u_sxy   = r_sxy + SQW'(pxy);
            end else begin
                u_ovf = 1'b1;
            end
        end

        if (close_set) begin
            n_count = '0;
            n_sx    = '0;
            n_sy    = '0;
            n_sxx   = '0;
            n_syy   = '0;
            n_sxy   = '0;
            n_ovf   = 1'b0;
        end else begin
            n_count = u_count;
            n_sx    = u_sx;
            n_sy    = u_sy;
            n_sxx   = u_sxx;
            n_syy   = u_syy;
            n_sxy   = u_sxy;
            n_ovf   = u_ovf;
        end

        o_push    = accept && ((i_in.op == OP_EVAL) || i_in.last_sample);
        o_job.op  = i_in.op;
        o_job.x   = i_in.x_value;
        o_job.ovf = u_ovf;
        o_job.n   = 64'(u_count);
        o_job.sx  = 64'(u_sx);
        o_job.sy  = 64'(u_sy);
        o_job.sxx = 64'(u_sxx);
        o_job.syy = 64'(u_syy);
        o_job.sxy = 64'(u_sxy);
    end

    assign i_in.ready = !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_sxx   <= '0;
            r_syy   <= '0;
            r_sxy   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_sx    <= n_sx;
            r_sy    <= n_sy;
            r_sxx   <= n_sxx;
            r_syy   <= n_syy;
            r_sxy   <= n_sxy;
            r_ovf   <= n_ovf;
        end
    end

endmodule

### hw/rtl/lsf_back.sv
// Back end of the line fitter: a sequencer that runs each job through the
// shared arithmetic unit and drives the result register. Uses lsf_pkg.
module lsf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  lsf_pkg::t_job       i_job,
    output logic                o_job_pop,
    output lsf_pkg::t_arith_req o_req,
    output logic signed [127:0] o_a,
    output logic [63:0]         o_b,
    input  logic                i_done,
    input  logic signed [127:0] i_res,
    lsf_out_if.source           o_out
);
    import lsf_pkg::*;

    t_bstate             r_state, n_state;
    logic                r_issued;
    t_job                r_job;
    logic signed [63:0]  r_t;
    logic signed [63:0]  r_nxx, r_nyy, r_nxy;
    logic signed [127:0] r_prod;
    logic signed [SLOPE_W-1:0] r_fslope;
    logic signed [ICPT_W-1:0]  r_ficpt;
    logic signed [CORR_W-1:0]  r_corr;
    logic                r_degen;

    logic                r_out_valid;
    logic                r_o_kind;
    logic signed [SLOPE_W-1:0] r_o_slope;
    logic signed [ICPT_W-1:0]  r_o_icpt;
    logic signed [CORR_W-1:0]  r_o_corr;
    logic signed [ICPT_W-1:0]  r_o_pred;
    logic                r_o_degenerate;
    logic                r_o_overflowed;

    logic                arith_step;
    logic                out_load;
    logic                degen_now;
    logic signed [63:0]  nxx_now;

    always_comb begin
        nxx_now   = r_t - i_res[63:0];
        degen_now = (r_nxx <= 0);
    end

    // Next step.
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    n_state = (i_job.op == OP_EVAL) ? B_PRED : B_NXX_A;
                end
            end
            B_NXX_A:   if (i_done) n_state = B_NXX_B;
            B_NXX_B:   if (i_done) n_state = B_NYY_A;
            B_NYY_A:   if (i_done) n_state = B_NYY_B;
            B_NYY_B:   if (i_done) n_state = B_NXY_A;
            B_NXY_A:   if (i_done) n_state = B_NXY_B;
            B_NXY_B:   if (i_done) n_state = degen_now ? B_ICPT : B_SLOPE;
            B_SLOPE:   if (i_done) n_state = B_SXPROD;
            B_SXPROD:  if (i_done) n_state = B_ICPT;
            B_ICPT: begin
                if (i_done) begin
                    n_state = (r_degen || r_nyy <= 0) ? B_OUT : B_PROD_NN;
                end
            end
            B_PROD_NN: if (i_done) n_state = B_ROOT;
            B_ROOT:    if (i_done) n_state = (i_res == '0) ? B_OUT : B_CORR;
            B_CORR:    if (i_done) n_state = B_OUT;
            B_PRED:    if (i_done) n_state = B_OUT;
            B_OUT:     if (out_load) n_state = B_IDLE;
            default:   n_state = B_IDLE;
        endcase
    end

    // Operand selection and handshakes.
    always_comb begin
        arith_step = !(r_state inside {B_IDLE, B_OUT});
        o_job_pop  = (r_state == B_IDLE) && i_job_valid;
        out_load   = (r_state == B_OUT) && (!r_out_valid || o_out.ready);
        o_req.start = arith_step && !r_issued;
        o_req.op    = AOP_MUL;
        o_a         = '0;
        o_b         = '0;
        case (r_state)
            B_NXX_A: begin
                o_a = 128'($signed(r_job.n));
                o_b = r_job.sxx;
            end
            B_NXX_B: begin
                o_a = 128'(r_job.sx);
                o_b = r_job.sx;
            end
            B_NYY_A: begin
                o_a = 128'($signed(r_job.n));
                o_b = r_job.syy;
            end
            B_NYY_B: begin
                o_a = 128'(r_job.sy);
                o_b = r_job.sy;
            end
            B_NXY_A: begin
                o_a = 128'($signed(r_job.n));
                o_b = r_job.sxy;
            end
            B_NXY_B: begin
                o_a = 128'(r_job.sx);
                o_b = r_job.sy;
            end
            B_SLOPE: begin
                o_req.op = AOP_DIV;
                o_a      = 128'(r_nxy) <<< 16;
                o_b      = r_nxx;
            end
            B_SXPROD: begin
                o_a = 128'(r_fslope);
                o_b = r_job.sx;
            end
            B_ICPT: begin
                o_req.op = AOP_DIV;
                o_a      = (128'(r_job.sy) <<< 16) - r_prod;
                o_b      = r_job.n;
            end
            B_PROD_NN: begin
                o_a = 128'(r_nxx);
                o_b = r_nyy;
            end
            B_ROOT: begin
                o_req.op = AOP_SQRT;
                o_a      = r_prod;
            end
            B_CORR: begin
                o_req.op = AOP_DIV;
                o_a      = 128'(r_nxy) <<< 15;
                o_b      = r_t;
            end
            B_PRED: begin
                o_a = 128'(r_fslope);
                o_b = 64'(r_job.x);
            end
            default: begin
                o_a = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_fslope    <= '0;
            r_ficpt     <= '0;
        end else begin
            r_state <= n_state;
            if (o_req.start) begin
                r_issued <= 1'b1;
            end else if (i_done) begin
                r_issued <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_done) begin
                case (r_state)
                    B_NXY_B:  if (degen_now) r_fslope <= '0;
                    B_SLOPE:  r_fslope <= SLOPE_W'(sat_to(i_res, SLOPE_W));
                    B_ICPT:   r_ficpt  <= ICPT_W'(sat_to(i_res, ICPT_W));
                    default:  r_fslope <= r_fslope;
                endcase
            end
        end

        if (o_job_pop) begin
            r_job <= i_job;
        end
        if (i_done) begin
            case (r_state)
                B_NXX_A, B_NYY_A, B_NXY_A: r_t <= i_res[63:0];
                B_NXX_B:  r_nxx <= nxx_now;
                B_NYY_B:  r_nyy <= nxx_now;
                B_NXY_B: begin
                    r_nxy   <= nxx_now;
                    r_degen <= degen_now;
                    r_prod  <= '0;
                    r_corr  <= '0;
                end
                B_SXPROD, B_PROD_NN, B_PRED: r_prod <= i_res;
                B_ICPT: begin
                    if (!r_degen && r_nyy <= 0) begin
                        r_corr <= CORR_W'(sat_to(128'sd32767, CORR_W));
                    end
                end
                B_ROOT: begin
                    r_t <= i_res[63:0];
                    if (i_res == '0) begin
                        r_corr <= CORR_W'(sat_to(128'sd32767, CORR_W));
                    end
                end
                B_CORR:  r_corr <= CORR_W'(sat_to(i_res, CORR_W));
                default: r_t <= r_t;
            endcase
        end

        if (out_load) begin
            r_o_kind   <= r_job.op;
            r_o_slope  <= r_fslope;
            r_o_icpt   <= r_ficpt;
            if (r_job.op == OP_EVAL) begin
                r_o_corr       <= '0;
                r_o_pred       <= ICPT_W'(sat_to(r_prod + 128'(r_ficpt), ICPT_W));
                r_o_degenerate <= 1'b0;
                r_o_overflowed <= 1'b0;
            end else begin
                r_o_corr       <= r_corr;
                r_o_pred       <= '0;
                r_o_degenerate <= r_degen;
                r_o_overflowed <= r_job.ovf;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_kind = r_o_kind;
    assign o_out.slope       = r_o_slope;
    assign o_out.intercept   = r_o_icpt;
    assign o_out.correlation = r_o_corr;
    assign o_out.prediction  = r_o_pred;
    assign o_out.degenerate  = r_o_degenerate;
    assign o_out.overflowed  = r_o_overflowed;

    a_pred_flags_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_kind == KIND_PRED) |->
        (!r_o_degenerate && !r_o_overflowed && r_o_corr == '0))
        else $error("prediction result carries fit flags");
    a_done_was_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |-> r_issued) else $error("arith result without a request");

endmodule

### hw/rtl/least_squares_line_fit.sv
// Top level of the least-squares straight-line fitter: front end, job queue,
// back-end sequencer and shared arithmetic unit. Uses lsf_pkg and lsf_ifs.
//
//  Channel  Direction  Carries
//  i_in     in         op, x_value, y_value, last_sample
//  o_out    out        result_kind, slope, intercept, correlation,
//                      prediction, degenerate, overflowed
//
// A sample transfer is absorbed by the front end, whose three 16x16
// multipliers feed the running sums directly. A closing sample or a
// query becomes a job in a two-entry queue; the front end stalls only when
// that queue is full. The back end runs each job through one serial unit;
// a fit skips the slope steps when the x values have no spread, and the
// correlation steps then or when y is flat, and a query needs one multiply.
// Reset is synchronous and active low and clears the sums, the stored line,
// the queue and the valid flag of the result register; a result waits in
// its register while the back end goes on to the next job.
module least_squares_line_fit #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lsf_in_if.sink    i_in,
    lsf_out_if.source o_out
);
    import lsf_pkg::*;

    // Jobs between the front end and the back end.
    t_job                q_in_job;
    t_job                q_out_job;
    logic                q_push;
    logic                q_pop;
    logic                q_valid;
    logic                q_full;

    // Shared arithmetic unit.
    t_arith_req          a_req;
    logic signed [127:0] a_a;
    logic [63:0]         a_b;
    logic                a_done;
    logic signed [127:0] a_res;

    // The front end keeps the sums of the open set and closes it on the
    // sample marked last; dropped samples past capacity only set a flag.
    lsf_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_job   (q_in_job)
    );

    lsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .i_pop   (q_pop),
        .o_job   (q_out_job),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    // The back end takes jobs strictly in order, so a query always sees the
    // line left by the fits that went before it.
    lsf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_out_job),
        .o_job_pop   (q_pop),
        .o_req       (a_req),
        .o_a         (a_a),
        .o_b         (a_b),
        .i_done      (a_done),
        .i_res       (a_res),
        .o_out       (o_out)
    );

    lsf_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (a_req),
        .i_a     (a_a),
        .i_b     (a_b),
        .o_done  (a_done),
        .o_res   (a_res)
    );

endmodule
